>>> rtl/kdce_pkg.sv
// Package for the key frame delta coordinate encoder.
// Holds the word types, function codes and sizing constants; no dependencies.
package kdce_pkg;

	// Slot storage sizing: three coordinate slots per atom.
	localparam int MAX_ATOMS = 4096;
	localparam int SLOTS     = 3 * MAX_ATOMS;
	localparam int SLOT_AW   = $clog2(SLOTS);

	// Reset value of the key interval register.
	localparam logic [15:0] KEY_INTERVAL_RESET = 16'd32;

	// Saturation limits of the delta byte.
	localparam logic signed [32:0] DELTA_MIN = -33'sd128;
	localparam logic signed [32:0] DELTA_MAX = 33'sd127;

	// Function codes of an input word.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_FRAME = 1'b1;

	// Input word.
	typedef struct packed {
		logic               func;
		logic [13:0]        coord_index;
		logic signed [31:0] coord_value;
		logic               last_of_frame;
	} item_t;

	// Result word.
	typedef struct packed {
		logic               delta_valid;
		logic signed [7:0]  delta_byte;
		logic               key_valid;
		logic signed [31:0] key_value;
		logic [31:0]        frame_count;
		logic               record_end;
	} result_t;

	// Frame state seen by the datapath for the word at stage one.
	typedef struct packed {
		logic        delta_en;
		logic        is_key;
		logic [31:0] frame_count;
	} frame_state_t;

endpackage

>>> rtl/kdce_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// A read at the address being written returns the old contents. No dependencies.
module kdce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/kdce_ctrl.sv
// Frame control: key interval register, key countdown and frame counter.
// Depends on kdce_pkg.
module kdce_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_data,
	input  logic                  adv,
	input  logic                  func,
	input  logic                  last_of_frame,
	output kdce_pkg::frame_state_t fs
);

	logic [15:0]        key_interval_q;
	logic signed [16:0] countdown_q;
	logic [31:0]        frame_cnt_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_interval_q <= kdce_pkg::KEY_INTERVAL_RESET;
		end else if (cfg_we) begin
			key_interval_q <= cfg_data;
		end
	end

	// A load re-arms the countdown and clears the frame number; the end of a
	// frame re-arms after a key frame, counts down otherwise, and bumps the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
			frame_cnt_q <= '0;
		end else if (adv) begin
			if (func == kdce_pkg::FUNC_LOAD) begin
				countdown_q <= {1'b0, key_interval_q};
				frame_cnt_q <= '0;
			end else if (last_of_frame) begin
				if (countdown_q[16]) begin
					countdown_q <= {1'b0, key_interval_q};
				end else begin
					countdown_q <= countdown_q - 17'sd1;
				end
				frame_cnt_q <= frame_cnt_q + 32'd1;
			end
		end
	end

	// State presented to the datapath.
	assign fs.delta_en    = (key_interval_q > 16'd1);
	assign fs.is_key      = countdown_q[16];
	assign fs.frame_count = frame_cnt_q;

endmodule

>>> rtl/kdce_calc.sv
// Result datapath: saturated delta and key value for one coordinate word.
// Depends on kdce_pkg.
module kdce_calc (
	input  kdce_pkg::item_t        item,
	input  logic                   in_range,
	input  logic signed [31:0]     prev_value,
	input  kdce_pkg::frame_state_t fs,
	output kdce_pkg::result_t      result
);

	logic signed [31:0] prev;
	logic signed [32:0] diff;
	logic signed [7:0]  sat;
	logic               is_frame;

	// Difference against the stored coordinate, clamped to a signed byte.
	always_comb begin
		prev     = in_range ? prev_value : 32'sd0;
		diff     = 33'(item.coord_value) - 33'(prev);
		is_frame = (item.func == kdce_pkg::FUNC_FRAME);
		if (diff < kdce_pkg::DELTA_MIN) begin
			sat = -8'sd128;
		end else if (diff > kdce_pkg::DELTA_MAX) begin
			sat = 8'sd127;
		end else begin
			sat = diff[7:0];
		end
	end

	// Loads always carry a key value at frame zero; frames follow the countdown.
	always_comb begin
		result.record_end = item.last_of_frame;
		if (!is_frame) begin
			result.delta_valid = 1'b0;
			result.delta_byte  = '0;
			result.key_valid   = 1'b1;
			result.key_value   = item.coord_value;
			result.frame_count = '0;
		end else begin
			result.delta_valid = fs.delta_en;
			result.delta_byte  = fs.delta_en ? sat : 8'sd0;
			result.key_valid   = fs.is_key;
			result.key_value   = fs.is_key ? item.coord_value : 32'sd0;
			result.frame_count = fs.frame_count;
		end
	end

endmodule

>>> rtl/keyframe_delta_coord_encoder_top.sv
// An accepted word is held in the stage one register and then in the output register, which
// raises result_valid; a stalled result can hold the word in either register.
// Throughput: one word per cycle unless a stalled result holds it off; each word reads its slot once.
// The slot write is issued at accept, so the next word always sees it without forwarding.
// Reset clears the pipeline valids, key countdown and frame counter and sets the key
// interval to 32; the slot memory is not cleared and a slot must be loaded before use.
// Depends on kdce_pkg, kdce_ram, kdce_ctrl and kdce_calc.
module keyframe_delta_coord_encoder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  kdce_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output kdce_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);

	kdce_pkg::item_t               item_s1;
	logic                          valid_s1;
	logic                          in_range_s1;
	logic                          in_range;
	logic [31:0]                   prev_rdata;
	logic [kdce_pkg::SLOT_AW-1:0]  slot_addr;
	kdce_pkg::frame_state_t        fs;
	kdce_pkg::result_t             calc_result;
	kdce_pkg::result_t             result_q;
	logic                          result_valid_q;
	logic                          out_free;
	logic                          s1_go;
	logic                          item_acc;

	// Handshake: stage one moves on when the output register is free or drains.
	assign out_free   = !result_valid_q || !result_stall;
	assign s1_go      = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign item_acc   = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign slot_addr = kdce_pkg::SLOT_AW'(item.coord_index);
	assign in_range  = (32'(item.coord_index) < 32'(kdce_pkg::SLOTS));

	// Slot memory: read old value and, for an in-range index, store new value in the accept cycle.
	kdce_ram #(
		.WIDTH(32),
		.DEPTH(kdce_pkg::SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (item_acc && in_range),
		.waddr(slot_addr),
		.wdata(item.coord_value),
		.re   (item_acc),
		.raddr(slot_addr),
		.rdata(prev_rdata)
	);

	// Stage one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1     <= item;
			in_range_s1 <= in_range;
		end
	end

	// Countdown and frame counter advance in word order as stage one retires.
	kdce_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.adv          (s1_go),
		.func         (item_s1.func),
		.last_of_frame(item_s1.last_of_frame),
		.fs           (fs)
	);

	kdce_calc u_calc (
		.item      (item_s1),
		.in_range  (in_range_s1),
		.prev_value(prev_rdata),
		.fs        (fs),
		.result    (calc_result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			result_q <= calc_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Input is only held off while stage one holds a word.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with stage one empty");

	// A retiring load word restarts the frame numbering at zero.
	a_load_clears_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && item_s1.func == kdce_pkg::FUNC_LOAD) |=> (fs.frame_count == 32'd0))
		else $error("frame counter not cleared by load");

	// The end of a key frame re-arms the countdown.
	a_key_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && item_s1.func == kdce_pkg::FUNC_FRAME && item_s1.last_of_frame && fs.is_key)
		|=> !fs.is_key)
		else $error("key countdown not re-armed after key frame");

	// A held result is only dropped after it was taken.
	a_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(!result_stall))
		else $error("result dropped while stalled");

endmodule
